// ----- hw/rtl/hpf_pkg.sv -----
// shared types and constants for the height plateau finder
package hpf_pkg;

	localparam int HEIGHT_W = 16;
	localparam int INDEX_W = 32;
	localparam int RUN_W = 8;
	localparam int PNUM_W = 3;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int DEF_MAX_PLATEAUS = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_TOLERANCE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_LENGTH = 2'd3;

	localparam logic [HEIGHT_W-1:0] RST_MIN_HEIGHT = 16'd112;
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT_GAP = 16'd32;
	localparam logic [HEIGHT_W-1:0] RST_MATCH_TOLERANCE = 16'd48;
	localparam logic [RUN_W-1:0] RST_MIN_RUN_LENGTH = 8'd20;

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic restart;
	} sample_t;

	typedef struct packed {
		logic [INDEX_W-1:0] begin_index;
		logic [INDEX_W-1:0] end_index;
		logic [PNUM_W-1:0] plateau_number;
		logic [HEIGHT_W-1:0] plateau_height;
		logic list_full;
	} result_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0] min_height;
		logic [HEIGHT_W-1:0] height_gap;
		logic [HEIGHT_W-1:0] match_tolerance;
		logic [RUN_W-1:0] min_run_length;
	} cfg_t;

	function automatic logic [HEIGHT_W-1:0] height_dist(input logic [HEIGHT_W-1:0] a,
			input logic [HEIGHT_W-1:0] b);
		height_dist = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- hw/rtl/hpf_proc.sv -----
// plateau tracking state and per-sample decision logic
module hpf_proc #(
	parameter int MAX_PLATEAUS = hpf_pkg::DEF_MAX_PLATEAUS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  hpf_pkg::sample_t item,
	input  hpf_pkg::cfg_t cfg,
	output logic res_valid,
	output hpf_pkg::result_t res
);
	import hpf_pkg::*;

	localparam int CNT_W = $clog2(MAX_PLATEAUS + 1);

	logic [INDEX_W-1:0] idx_q;
	logic trk_q;
	logic [INDEX_W-1:0] start_q;
	logic [HEIGHT_W-1:0] rh_q;
	logic [RUN_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;
	logic [HEIGHT_W-1:0] found_q [MAX_PLATEAUS];

	logic [INDEX_W-1:0] idx_n;
	logic trk_n;
	logic [INDEX_W-1:0] start_n;
	logic [HEIGHT_W-1:0] rh_n;
	logic [RUN_W-1:0] len_n;
	logic [CNT_W-1:0] cnt_n;
	logic emit;

	always_comb begin
		logic [INDEX_W-1:0] idx_e;
		logic trk_e;
		logic [RUN_W-1:0] len_e;
		logic [CNT_W-1:0] cnt_e;
		logic ok;
		logic [RUN_W-1:0] len_i;
		idx_e = item.restart ? '0 : idx_q;
		trk_e = item.restart ? 1'b0 : trk_q;
		len_e = item.restart ? '0 : len_q;
		cnt_e = item.restart ? '0 : cnt_q;
		trk_n = trk_e;
		start_n = item.restart ? '0 : start_q;
		rh_n = item.restart ? '0 : rh_q;
		len_n = len_e;
		cnt_n = cnt_e;
		emit = 1'b0;
		ok = (item.height > cfg.min_height) && (item.height > cfg.height_gap);
		for (int k = 0; k < MAX_PLATEAUS; k++) begin
			if ((CNT_W'(k) < cnt_e) &&
					(height_dist(item.height, found_q[k]) <= cfg.height_gap))
				ok = 1'b0;
		end
		len_i = (len_e == '1) ? len_e : len_e + 1'b1;
		if (cnt_e < CNT_W'(MAX_PLATEAUS)) begin
			if (!trk_e) begin
				if (ok) begin
					trk_n = 1'b1;
					start_n = idx_e;
					rh_n = item.height;
				end
			end else begin
				if (height_dist(rh_n, item.height) < cfg.match_tolerance) begin
					len_n = len_i;
				end else begin
					trk_n = 1'b0;
					len_n = '0;
				end
				if (len_n > cfg.min_run_length) begin
					emit = 1'b1;
					cnt_n = cnt_e + 1'b1;
					trk_n = 1'b0;
					len_n = '0;
				end
			end
		end
		idx_n = (idx_e == '1) ? idx_e : idx_e + 1'b1;
		res_valid = fire && emit;
		res.begin_index = start_n;
		res.end_index = idx_e;
		res.plateau_number = PNUM_W'(cnt_n);
		res.plateau_height = rh_n;
		res.list_full = (cnt_n >= CNT_W'(MAX_PLATEAUS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			trk_q <= 1'b0;
			start_q <= '0;
			rh_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			idx_q <= idx_n;
			trk_q <= trk_n;
			start_q <= start_n;
			rh_q <= rh_n;
			len_q <= len_n;
			cnt_q <= cnt_n;
		end
	end

	// found heights, written at the current count
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_PLATEAUS; k++) begin
			if (fire && emit && (cnt_n == CNT_W'(k + 1)))
				found_q[k] <= rh_n;
		end
	end

endmodule

// ----- hw/rtl/hpf_outq.sv -----
// two-entry result queue between the decision logic and the result channel
module hpf_outq (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hpf_pkg::result_t din,
	output logic full,
	output logic result_valid,
	input  logic result_stall,
	output hpf_pkg::result_t result
);
	import hpf_pkg::*;

	logic [1:0] cnt_q;
	result_t ent0_q;
	result_t ent1_q;
	logic pop;

	assign pop = result_valid && !result_stall;
	assign result_valid = (cnt_q != 2'd0);
	assign full = (cnt_q == 2'd2);
	assign result = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if ((cnt_q == 2'd0 && push) || (cnt_q == 2'd1 && pop && push)) begin
			ent0_q <= din;
		end else if (cnt_q == 2'd2 && pop) begin
			ent0_q <= ent1_q;
		end
		if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2 && pop))) begin
			ent1_q <= din;
		end
	end

endmodule

// ----- hw/rtl/height_plateau_finder.sv -----
// top level of the height plateau finder
// samples come in on the sample channel (sample_valid / sample_stall), one
// transaction per height sample, with a restart flag that clears all tracking
// state and the sample index before that sample is handled.
// plateaus leave on the result channel (result_valid / result_stall), zero or
// one transaction per sample, in sample order.
// a sample is taken into an input register, decided there once the result
// queue has room and its result written into a two-entry result queue, from
// which it is offered on the result channel.
// one sample per cycle is sustained unless the result queue is full; the rate
// is set by the tracking registers, which every sample reads and writes.
// sample_stall rises only when the input register holds a sample and the
// result queue is full, so a stalled receiver stops intake after two results.
// registers are to be written through cfg_we / cfg_index / cfg_data while idle;
// the block does not enforce this. reset loads the default registers and clears
// the index, run and found plateau count; samples are accepted once it is released.
module height_plateau_finder #(
	parameter int MAX_PLATEAUS = hpf_pkg::DEF_MAX_PLATEAUS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_stall,
	input  hpf_pkg::sample_t sample,
	output logic result_valid,
	input  logic result_stall,
	output hpf_pkg::result_t result,
	input  logic cfg_we,
	input  logic [hpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hpf_pkg::CFG_W-1:0] cfg_data
);
	import hpf_pkg::*;

	cfg_t cfg_q;
	logic valid_s1;
	sample_t item_s1;
	logic fire;
	logic q_full;
	logic res_valid;
	result_t res;

	assign fire = valid_s1 && !q_full;
	assign sample_stall = valid_s1 && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_height <= RST_MIN_HEIGHT;
			cfg_q.height_gap <= RST_HEIGHT_GAP;
			cfg_q.match_tolerance <= RST_MATCH_TOLERANCE;
			cfg_q.min_run_length <= RST_MIN_RUN_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_HEIGHT: cfg_q.min_height <= cfg_data;
				REG_HEIGHT_GAP: cfg_q.height_gap <= cfg_data;
				REG_MATCH_TOLERANCE: cfg_q.match_tolerance <= cfg_data;
				REG_MIN_RUN_LENGTH: cfg_q.min_run_length <= cfg_data[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall)
			item_s1 <= sample;
	end

	hpf_proc #(
		.MAX_PLATEAUS(MAX_PLATEAUS)
	) u_proc (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.item(item_s1),
		.cfg(cfg_q),
		.res_valid(res_valid),
		.res(res)
	);

	hpf_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.din(res),
		.full(q_full),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule

// ----- test/tb_top.sv -----
// testbench for height_plateau_finder: directed and random sample streams checked by a scoreboard
`timescale 1ns / 100ps

module tb_top;
	import hpf_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int RANDOM_TARGET = 1100;

	class plateau_tracker;
		logic [HEIGHT_W-1:0] min_height;
		logic [HEIGHT_W-1:0] height_gap;
		logic [HEIGHT_W-1:0] match_tol;
		logic [RUN_W-1:0] min_run;
		logic [INDEX_W-1:0] sample_index;
		logic [INDEX_W-1:0] run_start;
		bit tracking;
		logic [HEIGHT_W-1:0] run_height;
		logic [RUN_W-1:0] run_length;
		logic [HEIGHT_W-1:0] found_heights [DEF_MAX_PLATEAUS];
		int found_count;
		result_t expected_plateaus [$];
		int mismatches;
		int checked;

		function new();
			min_height = RST_MIN_HEIGHT;
			height_gap = RST_HEIGHT_GAP;
			match_tol = RST_MATCH_TOLERANCE;
			min_run = RST_MIN_RUN_LENGTH;
			mismatches = 0;
			checked = 0;
			clear_all();
		endfunction

		function void clear_all();
			sample_index = '0;
			tracking = 1'b0;
			run_start = '0;
			run_height = '0;
			run_length = '0;
			for (int k = 0; k < DEF_MAX_PLATEAUS; k++)
				found_heights[k] = '0;
			found_count = 0;
		endfunction

		function logic [HEIGHT_W-1:0] height_diff(logic [HEIGHT_W-1:0] a, logic [HEIGHT_W-1:0] b);
			return (a > b) ? a - b : b - a;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
			case (idx)
				REG_MIN_HEIGHT: min_height = d;
				REG_HEIGHT_GAP: height_gap = d;
				REG_MATCH_TOLERANCE: match_tol = d;
				REG_MIN_RUN_LENGTH: min_run = d[RUN_W-1:0];
				default: ;
			endcase
		endfunction

		function bit is_ignored(sample_t s);
			return !s.restart && found_count >= DEF_MAX_PLATEAUS;
		endfunction

		function void note_sample(sample_t s);
			logic [INDEX_W-1:0] idx;
			logic [HEIGHT_W-1:0] h;
			bit fresh;
			result_t r;
			h = s.height;
			if (s.restart)
				clear_all();
			idx = sample_index;
			if (found_count < DEF_MAX_PLATEAUS) begin
				if (!tracking) begin
					fresh = (h > min_height) && (h > height_gap);
					for (int k = 0; k < found_count; k++)
						if (height_diff(h, found_heights[k]) <= height_gap)
							fresh = 1'b0;
					if (fresh) begin
						tracking = 1'b1;
						run_start = idx;
						run_height = h;
					end
				end else begin
					if (height_diff(run_height, h) < match_tol) begin
						if (run_length != 8'hFF)
							run_length++;
					end else begin
						tracking = 1'b0;
						run_length = '0;
					end
					if (run_length > min_run) begin
						found_heights[found_count] = run_height;
						found_count++;
						tracking = 1'b0;
						run_length = '0;
						r.begin_index = run_start;
						r.end_index = idx;
						r.plateau_number = PNUM_W'(found_count);
						r.plateau_height = run_height;
						r.list_full = (found_count >= DEF_MAX_PLATEAUS);
						expected_plateaus = {expected_plateaus, r};
					end
				end
			end
			if (sample_index != '1)
				sample_index++;
		endfunction

		function void check_plateau(result_t got);
			result_t want;
			if (expected_plateaus.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected plateau: begin %0d end %0d num %0d height %0h full %0b",
						got.begin_index, got.end_index, got.plateau_number,
						got.plateau_height, got.list_full);
				return;
			end
			want = expected_plateaus.pop_front();
			checked++;
			if (got.begin_index !== want.begin_index || got.end_index !== want.end_index ||
					got.plateau_number !== want.plateau_number ||
					got.plateau_height !== want.plateau_height ||
					got.list_full !== want.list_full) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("plateau mismatch: expected begin %0d end %0d num %0d height %0h full %0b",
						want.begin_index, want.end_index, want.plateau_number,
						want.plateau_height, want.list_full);
					$display("                  got      begin %0d end %0d num %0d height %0h full %0b",
						got.begin_index, got.end_index, got.plateau_number,
						got.plateau_height, got.list_full);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	sample_t sample;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	plateau_tracker tracker = new();
	bit hold_off_req = 1'b0;
	bit counting = 1'b0;
	int random_items = 0;
	int samples_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	longint cycles = 0;

	always #1 clk = ~clk;

	height_plateau_finder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99, 0);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic [HEIGHT_W-1:0] clamp_h(int v);
		if (v < 0)
			return '0;
		if (v > 65535)
			return '1;
		return HEIGHT_W'(v);
	endfunction

	function automatic logic [HEIGHT_W-1:0] jitter(logic [HEIGHT_W-1:0] h,
			logic [HEIGHT_W-1:0] tol);
		int off;
		if (tol <= 1)
			return h;
		off = int'($urandom_range(int'(tol) - 1, 0));
		if ($urandom_range(1, 0))
			return clamp_h(int'(h) + off);
		return clamp_h(int'(h) - off);
	endfunction

	function automatic logic [HEIGHT_W-1:0] pick_height();
		int lo;
		int k;
		int g;
		lo = int'(tracker.min_height > tracker.height_gap ? tracker.min_height :
			tracker.height_gap) + 1;
		if (tracker.found_count > 0 && $urandom_range(9, 0) == 0) begin
			k = $urandom_range(tracker.found_count - 1, 0);
			g = int'(tracker.height_gap) + 2;
			return clamp_h(int'(tracker.found_heights[k]) + int'($urandom_range(2 * g, 0)) - g);
		end
		if (lo > 65535)
			return HEIGHT_W'($urandom_range(65535, 0));
		if ($urandom_range(4, 0) == 0)
			return HEIGHT_W'($urandom_range(lo + 40 > 65535 ? 65535 : lo + 40, lo));
		return HEIGHT_W'($urandom_range(65535, lo));
	endfunction

	task automatic send_one(input logic [HEIGHT_W-1:0] h, input bit rst, input bit gaps);
		sample_t s;
		int g;
		s.height = h;
		s.restart = rst;
		if (gaps) begin
			g = pick_gap();
			if (g > 0) begin
				sample_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		if (counting && !tracker.is_ignored(s))
			random_items++;
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		tracker.note_sample(s);
		samples_sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		while (tracker.expected_plateaus.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [HEIGHT_W-1:0] mh, input logic [HEIGHT_W-1:0] gap,
			input logic [HEIGHT_W-1:0] tol, input logic [RUN_W-1:0] mrl);
		logic [CFG_W-1:0] run_word;
		run_word = {8'($urandom), mrl};
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_HEIGHT;
		cfg_data <= mh;
		@(posedge clk);
		tracker.write_reg(REG_MIN_HEIGHT, mh);
		cfg_index <= REG_HEIGHT_GAP;
		cfg_data <= gap;
		@(posedge clk);
		tracker.write_reg(REG_HEIGHT_GAP, gap);
		cfg_index <= REG_MATCH_TOLERANCE;
		cfg_data <= tol;
		@(posedge clk);
		tracker.write_reg(REG_MATCH_TOLERANCE, tol);
		cfg_index <= REG_MIN_RUN_LENGTH;
		cfg_data <= run_word;
		@(posedge clk);
		tracker.write_reg(REG_MIN_RUN_LENGTH, run_word);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_config();
		logic [HEIGHT_W-1:0] mh;
		logic [HEIGHT_W-1:0] gap;
		logic [HEIGHT_W-1:0] tol;
		logic [RUN_W-1:0] mrl;
		mh = ($urandom_range(3, 0) == 0) ? HEIGHT_W'($urandom) : HEIGHT_W'($urandom_range(2000, 0));
		gap = ($urandom_range(3, 0) == 0) ? HEIGHT_W'($urandom_range(8000, 0)) :
			HEIGHT_W'($urandom_range(400, 0));
		tol = ($urandom_range(4, 0) == 0) ? HEIGHT_W'($urandom) : HEIGHT_W'($urandom_range(1500, 1));
		mrl = ($urandom_range(9, 0) == 0) ? RUN_W'($urandom_range(60, 25)) :
			RUN_W'($urandom_range(24, 0));
		write_regs(mh, gap, tol, mrl);
	endtask

	task automatic send_plateau(input bit broken, input bit gaps);
		logic [HEIGHT_W-1:0] h;
		int len;
		h = pick_height();
		if (broken)
			len = $urandom_range(int'(tracker.min_run), 0) + 1;
		else
			len = int'(tracker.min_run) + 2 +
				(($urandom_range(3, 0) == 0) ? int'($urandom_range(3, 0)) : 0);
		send_one(h, 1'b0, gaps);
		for (int i = 1; i < len; i++)
			send_one(jitter(h, tracker.match_tol), 1'b0, gaps);
		if (broken)
			send_one(h ^ 16'h8000, 1'b0, gaps);
	endtask

	task automatic run_random(input int budget);
		int start;
		int r;
		bit gaps;
		start = random_items;
		send_one(HEIGHT_W'($urandom), 1'b1, 1'b1);
		while (random_items - start < budget) begin
			gaps = ($urandom_range(3, 0) != 0);
			if (tracker.found_count >= DEF_MAX_PLATEAUS && $urandom_range(3, 0) != 0) begin
				send_one(HEIGHT_W'($urandom), 1'b1, gaps);
			end else begin
				r = $urandom_range(99, 0);
				if (r < 65)
					send_plateau(1'b0, gaps);
				else if (r < 80)
					send_plateau(1'b1, gaps);
				else if (r < 97)
					send_one(HEIGHT_W'($urandom), 1'b0, gaps);
				else
					send_one(HEIGHT_W'($urandom), 1'b1, gaps);
			end
		end
	endtask

	task automatic hold_and_flood();
		hold_off_req = 1'b1;
		for (int i = 0; i < 40; i++)
			send_one(HEIGHT_W'($urandom), tracker.found_count >= DEF_MAX_PLATEAUS, 1'b0);
	endtask

	task automatic directed_part();
		send_one(16'd0, 1'b1, 1'b0);
		send_one(16'd112, 1'b0, 1'b0);
		send_one(16'd113, 1'b0, 1'b0);
		send_one(16'd160, 1'b0, 1'b1);
		send_one(16'd65, 1'b0, 1'b0);
		send_one(16'hFFFF, 1'b0, 1'b0);
		send_one(16'hFFD0, 1'b0, 1'b1);
		repeat (3) send_one(16'hFFFF, 1'b0, 1'b0);
		send_one(16'hFFDF, 1'b0, 1'b0);
		repeat (5) send_one(16'hFFDE, 1'b0, 1'b1);
		send_one(16'h5555, 1'b1, 1'b0);
		send_one(16'hAAAA, 1'b0, 1'b0);
		repeat (4) send_one(16'hAAAA, 1'b0, 1'b1);
		send_one(16'h0000, 1'b0, 1'b0);
	endtask

	// receiver: random stalls, long hold-off on request
	initial begin
		int r;
		int stall_left;
		int run_left;
		stall_left = 0;
		run_left = 0;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid === 1'b1 && result_stall === 1'b0)
				tracker.check_plateau(result);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
				run_left = 0;
			end
			if (stall_left == 0 && run_left == 0) begin
				r = $urandom_range(99, 0);
				if (r < 60)
					run_left = $urandom_range(40, 1);
				else if (r < 92)
					stall_left = $urandom_range(3, 1);
				else if (r < 98)
					stall_left = $urandom_range(12, 4);
				else
					stall_left = $urandom_range(60, 20);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				run_left--;
				result_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if ((sample_valid === 1'b1 && sample_stall === 1'b0) ||
					(result_valid === 1'b1 && result_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles, %0d plateaus outstanding",
					IDLE_LIMIT, tracker.expected_plateaus.size());
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_regs(16'd112, 16'd32, 16'd48, 8'd3);
		directed_part();
		drain();

		counting = 1'b1;
		write_regs(16'd0, 16'd0, 16'hFFFF, 8'd0);
		hold_and_flood();
		run_random(60);
		drain();
		write_regs(16'hFFFF, 16'd32, 16'd48, 8'd5);
		run_random(30);
		drain();
		write_regs(16'd0, 16'hFFFF, 16'd48, 8'd5);
		run_random(30);
		drain();
		// zero tolerance: every sample after a start ends the run
		write_regs(16'd200, 16'd40, 16'd0, 8'd2);
		run_random(60);
		drain();
		write_regs(16'd150, 16'd50, 16'd1, 8'd254);
		run_random(260);
		drain();
		// saturated run length never exceeds 255
		write_regs(16'd150, 16'd50, 16'd300, 8'd255);
		run_random(260);
		drain();
		write_regs(RST_MIN_HEIGHT, RST_HEIGHT_GAP, RST_MATCH_TOLERANCE, RST_MIN_RUN_LENGTH);
		run_random(120);
		drain();
		while (random_items < RANDOM_TARGET) begin
			random_config();
			run_random(120);
			drain();
		end

		$display("run covered %0d samples under %0d register settings in %0d cycles",
			samples_sent, settings_used, cycles);
		$display("%0d plateaus checked, %0d mismatches, receiver held off %0d cycles once",
			tracker.checked, tracker.mismatches, HOLD_OFF_CYCLES);
		if (tracker.mismatches == 0 && tracker.expected_plateaus.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
